// File: src/spf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, codes and helpers for the spectrum peak finder.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int FREQ_W = 24;
    localparam int LVL_W  = 16;
    localparam int RES_W  = 17;
    localparam int DIV_W  = 20;
    localparam int DVR_W  = 4;

    localparam logic [1:0] KIND_CARRIER = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_SHORT   = 2'd2;

    localparam logic [1:0] REG_SATELLITE = 2'd0;
    localparam logic [1:0] REG_LAG       = 2'd1;
    localparam logic [1:0] REG_PFLOOR    = 2'd2;
    localparam logic [1:0] REG_PCEIL     = 2'd3;

    localparam logic [DVR_W-1:0] DIV_SAT  = 4'd10;
    localparam logic [DVR_W-1:0] DIV_WIDE = 4'd5;

    // ceil(2^23/10) == ceil(2^22/5); exact for every 20-bit dividend
    localparam logic [DIV_W-1:0] DIV_RECIP  = 20'd838861;
    localparam int               SHIFT_SAT  = 23;
    localparam int               SHIFT_WIDE = 22;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_CNT,
        S_CNT_END,
        S_HEAD,
        S_DIV,
        S_MERGE,
        S_SCAN_A,
        S_SCAN_B,
        S_SCAN_C,
        S_OUT_WAIT,
        S_FIN_WAIT
    } t_state;

    // lift empty or low readings to the floor
    function automatic logic signed [17:0] clamp_level(input logic signed [15:0] lvl,
                                                        input logic signed [16:0] fl);
        logic signed [17:0] l18;
        logic signed [17:0] f18;
        l18 = 18'(lvl);
        f18 = 18'(fl);
        if (lvl == 16'sd0 || l18 < f18) begin
            return f18;
        end
        return l18;
    endfunction

endpackage
`default_nettype wire

// File: src/spf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spf_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module spf_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: src/spf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spf_div
// Divide by five or ten through one reciprocal multiply, result next cycle.
// ----------------------------------------------------------------------------
module spf_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [spf_pkg::DIV_W-1:0]     i_dividend,
    input  wire logic [spf_pkg::DVR_W-1:0]     i_divisor,
    output logic                               o_done,
    output logic      [spf_pkg::DIV_W-1:0]     o_quotient
);

    localparam int PW = 2 * spf_pkg::DIV_W;

    logic [spf_pkg::DIV_W-1:0] r_quo, n_quo;
    logic                      r_done;
    logic [PW-1:0]             prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        if (i_start) begin
            r_quo <= n_quo;
        end
    end

    always_comb begin
        prod = PW'(i_dividend) * PW'(spf_pkg::DIV_RECIP);
        if (i_divisor == spf_pkg::DIV_SAT) begin
            n_quo = spf_pkg::DIV_W'(prod >> spf_pkg::SHIFT_SAT);
        end else begin
            n_quo = spf_pkg::DIV_W'(prod >> spf_pkg::SHIFT_WIDE);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// File: src/spectrum_peak_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_peak_finder
// Sweep loader, percentile floor search, ceiling headroom and lagged edge scan.
// ----------------------------------------------------------------------------
// Samples load one per cycle into a single sample memory while the block is
// in its load phase. The request carrying last starts processing, during which
// no input is taken: a 16-pass bitwise search for the 5th-percentile level
// (one memory read per cycle within a pass), the headroom scaling through one
// reciprocal multiply, then two reads per scanned sample through the one read
// port. Each result is held until it is taken, and the scan waits meanwhile.
module spectrum_peak_finder #(
    parameter int MAX_SAMPLES = 4096,
    parameter int MAX_PEAKS   = 63
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [23:0] i_frequency,
    input  wire logic [15:0] i_level,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [23:0]      o_frequency_res,
    output logic [16:0]      o_level_res,
    output logic [16:0]      o_ceiling,
    output logic             o_overflow,
    output logic             o_end_of_run,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int IW = (CW > 4) ? CW : 4;
    localparam int KW = CW + 21;
    localparam int MW = spf_pkg::FREQ_W + spf_pkg::LVL_W;

    // configuration
    logic                r_sat;
    logic [3:0]          r_lag;
    logic signed [16:0]  r_pfloor;
    logic signed [16:0]  r_pceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat    <= 1'b1;
            r_lag    <= 4'd2;
            r_pfloor <= -17'sd1;
            r_pceil  <= -17'sd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                spf_pkg::REG_SATELLITE: r_sat    <= pwdata[0];
                spf_pkg::REG_LAG:       r_lag    <= pwdata[3:0];
                spf_pkg::REG_PFLOOR:    r_pfloor <= pwdata[16:0];
                spf_pkg::REG_PCEIL:     r_pceil  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            spf_pkg::REG_SATELLITE: prdata = {31'd0, r_sat};
            spf_pkg::REG_LAG:       prdata = {28'd0, r_lag};
            spf_pkg::REG_PFLOOR:    prdata = 32'(r_pfloor);
            spf_pkg::REG_PCEIL:     prdata = 32'(r_pceil);
            default:                prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // sequencer state
    spf_pkg::t_state     r_state, n_state;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_nz, n_nz;
    logic signed [15:0]  r_max, n_max;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_rd_v, n_rd_v;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [15:0]         r_prefix, n_prefix;
    logic [3:0]          r_bit, n_bit;
    logic signed [16:0]  r_floor, n_floor;
    logic signed [16:0]  r_ceil, n_ceil;
    logic                r_neg, n_neg;
    logic [14:0]         r_thr, n_thr;
    logic [IW-1:0]       r_i, n_i;
    logic signed [17:0]  r_prv, n_prv;
    logic [23:0]         r_xprv, n_xprv;
    logic                r_armed, n_armed;
    logic signed [17:0]  r_peak, n_peak;
    logic [23:0]         r_rise_f, n_rise_f;
    logic [5:0]          r_emit, n_emit;
    logic                r_ovf, n_ovf;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_kind, n_kind;
    logic [23:0]         r_freq_res, n_freq_res;
    logic [16:0]         r_lvl_res, n_lvl_res;
    logic [16:0]         r_ceil_res, n_ceil_res;
    logic                r_ovf_res, n_ovf_res;
    logic                r_eor, n_eor;

    // memory and divider hookup
    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    logic [MW-1:0]       mem_q;
    logic                div_start;
    logic [19:0]         div_mag;
    logic [3:0]          div_dvr;
    logic                div_done;
    logic [19:0]         div_q;

    spf_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_SAMPLES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata ({i_frequency, i_level}),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    spf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_mag),
        .i_divisor  (div_dvr),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spf_pkg::S_LOAD;
            r_n         <= '0;
            r_nz        <= '0;
            r_max       <= 16'sh8000;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_nz        <= n_nz;
            r_max       <= n_max;
            r_rd_v      <= n_rd_v;
            r_out_valid <= n_out_valid;
        end
        r_k        <= n_k;
        r_addr     <= n_addr;
        r_cnt      <= n_cnt;
        r_prefix   <= n_prefix;
        r_bit      <= n_bit;
        r_floor    <= n_floor;
        r_ceil     <= n_ceil;
        r_neg      <= n_neg;
        r_thr      <= n_thr;
        r_i        <= n_i;
        r_prv      <= n_prv;
        r_xprv     <= n_xprv;
        r_armed    <= n_armed;
        r_peak     <= n_peak;
        r_rise_f   <= n_rise_f;
        r_emit     <= n_emit;
        r_ovf      <= n_ovf;
        r_kind     <= n_kind;
        r_freq_res <= n_freq_res;
        r_lvl_res  <= n_lvl_res;
        r_ceil_res <= n_ceil_res;
        r_ovf_res  <= n_ovf_res;
        r_eor      <= n_eor;
    end

    // datapath helpers
    logic signed [15:0]  q_lvl;
    logic [23:0]         q_freq;
    logic [15:0]         cand;
    logic [KW-1:0]       k_prod;
    logic signed [15:0]  fl16;
    logic signed [20:0]  top21;
    logic signed [20:0]  dev21;
    logic signed [20:0]  num;
    logic signed [17:0]  span;
    logic [IW-1:0]       i_prv;
    logic signed [17:0]  cur;
    logic signed [18:0]  thr19;
    logic                rise;
    logic                fall;
    logic                armed_a;
    logic signed [17:0]  peak_a;
    logic [23:0]         rise_a;
    logic [24:0]         mid;
    logic signed [16:0]  mg_floor;
    logic signed [16:0]  mg_ceil;

    always_comb begin
        q_lvl   = mem_q[15:0];
        q_freq  = mem_q[MW-1:16];
        cand    = r_prefix | 16'((17'd1 << r_bit) - 17'd1);
        k_prod  = (KW'(r_nz) * KW'(52429)) >> 20;
        fl16    = r_prefix ^ 16'h8000;
        top21   = 21'(r_max);
        dev21   = 21'(r_max) - 21'(fl16);
        if (r_sat) begin
            num = (top21 <<< 3) + (top21 <<< 1) + dev21;
        end else begin
            num = (top21 <<< 2) + top21 + (dev21 <<< 1);
        end
        div_mag = num[20] ? 20'(-num) : num[19:0];
        div_dvr = r_sat ? spf_pkg::DIV_SAT : spf_pkg::DIV_WIDE;

        mg_floor = r_floor;
        mg_ceil  = r_ceil;
        if (r_pfloor > 17'sd0 && r_pceil > 17'sd0) begin
            if (r_pfloor < r_floor) begin
                mg_floor = r_pfloor;
            end
            if (r_pceil > r_ceil) begin
                mg_ceil = r_pceil;
            end
        end
        span = 18'(mg_ceil) - 18'(mg_floor);

        i_prv   = r_i - IW'(r_lag);
        cur     = spf_pkg::clamp_level(q_lvl, r_floor);
        thr19   = $signed({4'd0, r_thr});
        rise    = (19'(cur) - 19'(r_prv)) > thr19;
        fall    = (19'(r_prv) - 19'(cur)) > thr19;
        armed_a = r_armed | rise;
        rise_a  = rise ? r_xprv : r_rise_f;
        peak_a  = (rise && !r_armed) ? cur : r_peak;
        if (armed_a && cur > peak_a) begin
            peak_a = cur;
        end
        mid = (25'(rise_a) + 25'(q_freq)) >> 1;
    end

    assign mem_we    = (r_state == spf_pkg::S_LOAD) && i_in_valid &&
                       (r_n < CW'(MAX_SAMPLES));
    assign div_start = (r_state == spf_pkg::S_HEAD);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_nz        = r_nz;
        n_max       = r_max;
        n_k         = r_k;
        n_addr      = r_addr;
        n_rd_v      = 1'b0;
        n_cnt       = r_cnt;
        n_prefix    = r_prefix;
        n_bit       = r_bit;
        n_floor     = r_floor;
        n_ceil      = r_ceil;
        n_neg       = r_neg;
        n_thr       = r_thr;
        n_i         = r_i;
        n_prv       = r_prv;
        n_xprv      = r_xprv;
        n_armed     = r_armed;
        n_peak      = r_peak;
        n_rise_f    = r_rise_f;
        n_emit      = r_emit;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_freq_res  = r_freq_res;
        n_lvl_res   = r_lvl_res;
        n_ceil_res  = r_ceil_res;
        n_ovf_res   = r_ovf_res;
        n_eor       = r_eor;
        mem_raddr   = r_addr[AW-1:0];
        o_in_ready  = 1'b0;

        // tally nonzero levels at or below the candidate, in offset-binary order
        if (r_rd_v && q_lvl != 16'sd0 && {~q_lvl[15], q_lvl[14:0]} <= cand) begin
            n_cnt = r_cnt + CW'(1);
        end

        unique case (r_state)
            spf_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_n < CW'(MAX_SAMPLES)) begin
                        n_n = r_n + CW'(1);
                        if (i_level != 16'sd0) begin
                            n_nz = r_nz + CW'(1);
                            if ($signed(i_level) > r_max) begin
                                n_max = i_level;
                            end
                        end
                    end
                    if (i_last) begin
                        n_state = spf_pkg::S_START;
                    end
                end
            end
            spf_pkg::S_START: begin
                n_k      = k_prod[CW-1:0];
                n_addr   = '0;
                n_cnt    = '0;
                n_prefix = '0;
                n_bit    = 4'd15;
                if (r_n <= CW'(1) || r_nz == '0) begin
                    n_kind      = spf_pkg::KIND_SHORT;
                    n_freq_res  = '0;
                    n_lvl_res   = '0;
                    n_ceil_res  = '0;
                    n_ovf_res   = 1'b0;
                    n_eor       = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = spf_pkg::S_FIN_WAIT;
                end else begin
                    n_state = spf_pkg::S_CNT;
                end
            end
            spf_pkg::S_CNT: begin
                if (r_addr < r_n) begin
                    n_rd_v = 1'b1;
                    n_addr = r_addr + CW'(1);
                end else if (!r_rd_v) begin
                    n_state = spf_pkg::S_CNT_END;
                end
            end
            spf_pkg::S_CNT_END: begin
                if (!(r_cnt > r_k)) begin
                    n_prefix = r_prefix | (16'd1 << r_bit);
                end
                n_addr = '0;
                n_cnt  = '0;
                if (r_bit == 4'd0) begin
                    n_state = spf_pkg::S_HEAD;
                end else begin
                    n_bit   = r_bit - 4'd1;
                    n_state = spf_pkg::S_CNT;
                end
            end
            spf_pkg::S_HEAD: begin
                n_floor = 17'(fl16);
                n_neg   = num[20];
                n_state = spf_pkg::S_DIV;
            end
            spf_pkg::S_DIV: begin
                if (div_done) begin
                    n_ceil  = r_neg ? 17'(-$signed({1'b0, div_q})) : div_q[16:0];
                    n_state = spf_pkg::S_MERGE;
                end
            end
            spf_pkg::S_MERGE: begin
                n_floor  = mg_floor;
                n_ceil   = mg_ceil;
                n_thr    = span[17:3];
                n_i      = IW'(r_lag);
                n_armed  = 1'b0;
                n_peak   = '0;
                n_rise_f = '0;
                n_emit   = '0;
                n_ovf    = 1'b0;
                n_state  = spf_pkg::S_SCAN_A;
            end
            spf_pkg::S_SCAN_A: begin
                mem_raddr = i_prv[AW-1:0];
                if (r_i >= IW'(r_n)) begin
                    n_kind      = spf_pkg::KIND_SUMMARY;
                    n_freq_res  = '0;
                    n_lvl_res   = r_floor;
                    n_ceil_res  = r_ceil;
                    n_ovf_res   = r_ovf;
                    n_eor       = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = spf_pkg::S_FIN_WAIT;
                end else begin
                    n_state = spf_pkg::S_SCAN_B;
                end
            end
            spf_pkg::S_SCAN_B: begin
                mem_raddr = r_i[AW-1:0];
                n_prv     = spf_pkg::clamp_level(q_lvl, r_floor);
                n_xprv    = q_freq;
                n_state   = spf_pkg::S_SCAN_C;
            end
            spf_pkg::S_SCAN_C: begin
                n_i      = r_i + IW'(1);
                n_armed  = armed_a;
                n_peak   = peak_a;
                n_rise_f = rise_a;
                n_state  = spf_pkg::S_SCAN_A;
                if (armed_a && fall && peak_a > 18'(r_floor)) begin
                    n_armed = 1'b0;
                    n_peak  = '0;
                    if (r_emit < 6'(MAX_PEAKS)) begin
                        n_emit      = r_emit + 6'd1;
                        n_kind      = spf_pkg::KIND_CARRIER;
                        n_freq_res  = mid[23:0];
                        n_lvl_res   = peak_a[16:0];
                        n_ceil_res  = '0;
                        n_ovf_res   = 1'b0;
                        n_eor       = 1'b0;
                        n_out_valid = 1'b1;
                        n_state     = spf_pkg::S_OUT_WAIT;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            spf_pkg::S_OUT_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = spf_pkg::S_SCAN_A;
                end
            end
            spf_pkg::S_FIN_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_n         = '0;
                    n_nz        = '0;
                    n_max       = 16'sh8000;
                    n_state     = spf_pkg::S_LOAD;
                end
            end
            default: n_state = spf_pkg::S_LOAD;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_frequency_res = r_freq_res;
    assign o_level_res     = r_lvl_res;
    assign o_ceiling       = r_ceil_res;
    assign o_overflow      = r_ovf_res;
    assign o_end_of_run    = r_eor;

endmodule
`default_nettype wire

// File: tb/sv/tb_spectrum_peak_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_peak_finder
// Drives spectrum sweeps into the peak finder and checks every carrier,
// summary and short-sweep result against a behavioral predictor, under random
// idling on both channels and with register settings changed between phases.
// ----------------------------------------------------------------------------
module tb_spectrum_peak_finder;

    localparam int NSAMP   = 4096;
    localparam int NPEAKS  = 63;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [23:0] i_frequency;
    logic [15:0] i_level;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [23:0] o_frequency_res;
    logic [16:0] o_level_res;
    logic [16:0] o_ceiling;
    logic        o_overflow;
    logic        o_end_of_run;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spectrum_peak_finder uut (.*);

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] freq;
        logic [16:0] lvl;
        logic [16:0] ceil;
        logic        ovf;
        logic        eor;
    } t_peak_rec;

    t_peak_rec   expected_q[$];
    int          n_errors;
    int          n_results;
    int          n_sweeps;
    int          n_items;
    bit          quiet;

    // predictor state
    logic [23:0] sweep_freq[NSAMP];
    int          sweep_lvl[NSAMP];
    int          sorted_lvl[NSAMP];
    int          sweep_len;
    bit          cfg_sat;
    int          cfg_lag;
    int          cfg_pfloor;
    int          cfg_pceil;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("[spectrum_peak_finder] ERROR");
        $finish;
    end

    function automatic void push_rec(logic [1:0] k, logic [23:0] f, int l, int c,
                                     logic ov, logic e);
        t_peak_rec r;
        r.kind = k;
        r.freq = f;
        r.lvl  = l[16:0];
        r.ceil = c[16:0];
        r.ovf  = ov;
        r.eor  = e;
        expected_q.push_back(r);
    endfunction

    function automatic void find_peaks();
        int          nz;
        int          fl;
        int          top;
        int          dev;
        int          cl;
        int          thr;
        int          pk;
        int          cur;
        int          prv;
        int          t;
        int          j;
        int          emitted;
        bit          armed;
        bit          ovf;
        logic [23:0] rise_f;
        logic [24:0] mid;
        longint      num;
        nz = 0;
        if (sweep_len <= 1) begin
            push_rec(spf_pkg::KIND_SHORT, 0, 0, 0, 0, 1);
            return;
        end
        for (int i = 0; i < sweep_len; i++)
            if (sweep_lvl[i] != 0) sorted_lvl[nz++] = sweep_lvl[i];
        if (nz == 0) begin
            push_rec(spf_pkg::KIND_SHORT, 0, 0, 0, 0, 1);
            return;
        end
        for (int i = 1; i < nz; i++) begin
            t = sorted_lvl[i];
            j = i;
            while (j > 0 && sorted_lvl[j-1] > t) begin
                sorted_lvl[j] = sorted_lvl[j-1];
                j--;
            end
            sorted_lvl[j] = t;
        end
        fl  = sorted_lvl[nz/20];
        top = sorted_lvl[nz-1];
        dev = top - fl;
        if (cfg_sat) num = (longint'(top) * 10 + dev) / 10;
        else num = (longint'(top) * 5 + longint'(dev) * 2) / 5;
        cl = int'(num);
        if (cfg_pfloor > 0 && cfg_pceil > 0) begin
            if (cfg_pfloor < fl) fl = cfg_pfloor;
            if (cfg_pceil > cl) cl = cfg_pceil;
        end
        for (int i = 0; i < sweep_len; i++)
            if (sweep_lvl[i] < fl || sweep_lvl[i] == 0) sweep_lvl[i] = fl;
        thr = int'(unsigned'(cl - fl) / 8);
        armed = 0;
        ovf = 0;
        pk = 0;
        emitted = 0;
        rise_f = 0;
        for (int i = cfg_lag; i < sweep_len; i++) begin
            cur = sweep_lvl[i];
            prv = sweep_lvl[i - cfg_lag];
            if (longint'(cur) - prv > longint'(thr)) begin
                rise_f = sweep_freq[i - cfg_lag];
                if (!armed) pk = cur;
                armed = 1;
            end
            if (armed && cur > pk) pk = cur;
            if (armed && longint'(prv) - cur > longint'(thr) && pk > fl) begin
                mid = ({1'b0, rise_f} + {1'b0, sweep_freq[i]}) >> 1;
                if (emitted < NPEAKS) begin
                    push_rec(spf_pkg::KIND_CARRIER, mid[23:0], pk, 0, 0, 0);
                    emitted++;
                end else begin
                    ovf = 1;
                end
                armed = 0;
                pk = 0;
            end
        end
        push_rec(spf_pkg::KIND_SUMMARY, 0, fl, cl, ovf, 1);
    endfunction

    function automatic void load_sample(logic [23:0] f, logic [15:0] l, logic lst);
        if (sweep_len < NSAMP) begin
            sweep_freq[sweep_len] = f;
            sweep_lvl[sweep_len]  = int'($signed(l));
            sweep_len++;
        end
        if (lst) begin
            find_peaks();
            sweep_len = 0;
            n_sweeps++;
        end
    endfunction

    function automatic bit idle_now();
        return !quiet && $urandom_range(99) < 21;
    endfunction

    // valid drops only while idling or draining, so each step sees one drive
    task automatic send_sample(logic [23:0] f, logic [15:0] l, logic lst);
        while (idle_now()) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_frequency <= f;
        i_level     <= l;
        i_last      <= lst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        load_sample(f, l, lst);
        n_items++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        case (idx)
            spf_pkg::REG_SATELLITE: cfg_sat = val[0];
            spf_pkg::REG_LAG:       cfg_lag = int'(val[3:0]);
            spf_pkg::REG_PFLOOR:    cfg_pfloor = int'($signed(val[16:0]));
            default:                cfg_pceil = int'($signed(val[16:0]));
        endcase
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 0;
        while (expected_q.size() != 0 && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= 2000000) begin
            $display("[spectrum_peak_finder] ERROR");
            $finish;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_config(bit sat, int lg, int pf, int pc);
        drain();
        write_reg(spf_pkg::REG_SATELLITE, {31'd0, sat});
        write_reg(spf_pkg::REG_LAG, lg);
        write_reg(spf_pkg::REG_PFLOOR, pf);
        write_reg(spf_pkg::REG_PCEIL, pc);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    // one sweep with a few carriers: rise, plateau, fall over a noisy floor
    task automatic send_sweep(int len, int hi, int noise);
        logic [23:0] f;
        int          lvl;
        int          base;
        bit          in_peak;
        f = 24'($urandom);
        base = $urandom_range(200, 1200);
        in_peak = 0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 15) in_peak = !in_peak;
            lvl = in_peak ? base + $urandom_range(hi) : base + $urandom_range(noise);
            if ($urandom_range(99) < 4) lvl = 0;
            if ($urandom_range(99) < 3) lvl = int'($signed(16'($urandom)));
            send_sample(f, 16'(lvl), i == len - 1);
            f = f + 24'($urandom_range(1, 5000));
        end
    endtask

    task automatic test_directed();
        set_config(1, 2, -1, -1);
        send_sample(24'hFFFFFF, 16'sh7FFF, 1);
        send_sample(24'd0, 16'sd0, 0);
        send_sample(24'd10, 16'sd0, 1);
        send_sample(24'd0, 16'sh8000, 0);
        send_sample(24'hFFFFFF, 16'sh7FFF, 0);
        send_sample(24'hFFFFFE, 16'sh8000, 0);
        send_sample(24'd5, 16'sd100, 1);
        // rise at frequency zero
        send_sample(24'd0, 16'sd100, 0);
        send_sample(24'd100, 16'sd100, 0);
        send_sample(24'd200, 16'sd3000, 0);
        send_sample(24'd300, 16'sd3000, 0);
        send_sample(24'd400, 16'sd100, 0);
        send_sample(24'd500, 16'sd100, 1);
        set_config(0, 0, 500, 9000);
        send_sample(24'd0, 16'sd100, 0);
        send_sample(24'd100, 16'sd4000, 0);
        send_sample(24'd200, 16'sd100, 1);
        set_config(0, 10, 65535, 65535);
        send_sample(24'd1, 16'sd10, 0);
        send_sample(24'd2, 16'sd5000, 0);
        send_sample(24'd3, 16'sd10, 1);
    endtask

    task automatic test_overflow();
        set_config(1, 1, -32768, 65535);
        for (int i = 0; i < 140; i++)
            send_sample(24'(i * 7), (i % 2) ? 16'sd6000 : 16'sd50, i == 139);
    endtask

    task automatic test_random();
        set_config(1, 2, -1, -1);
        repeat (3) send_sweep($urandom_range(3, 30), 6000, 300);
        drain();
        set_config(0, 1, $urandom_range(1, 900), $urandom_range(2000, 20000));
        repeat (3) send_sweep($urandom_range(3, 30), 8000, 400);
        quiet = 1;
        set_config($urandom_range(1), $urandom_range(1, 3), -1, 3000);
        repeat (2) send_sweep($urandom_range(10, 30), 5000, 200);
        quiet = 0;
        set_config(1, 4, -1, -1);
        repeat (2) send_sweep($urandom_range(3, 25), 9000, 500);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result kind=%0d", o_kind);
                    n_errors++;
                end else begin
                    t_peak_rec e;
                    e = expected_q.pop_front();
                    if (e.kind != o_kind) begin
                        $error("kind exp %0d got %0d", e.kind, o_kind);
                        n_errors++;
                    end
                    if (e.freq != o_frequency_res) begin
                        $error("frequency_res exp %0d got %0d", e.freq, o_frequency_res);
                        n_errors++;
                    end
                    if (e.lvl != o_level_res) begin
                        $error("level_res exp %0d got %0d", $signed(e.lvl),
                               $signed(o_level_res));
                        n_errors++;
                    end
                    if (e.ceil != o_ceiling) begin
                        $error("ceiling exp %0d got %0d", $signed(e.ceil),
                               $signed(o_ceiling));
                        n_errors++;
                    end
                    if (e.ovf != o_overflow) begin
                        $error("overflow exp %0d got %0d", e.ovf, o_overflow);
                        n_errors++;
                    end
                    if (e.eor != o_end_of_run) begin
                        $error("end_of_run exp %0d got %0d", e.eor, o_end_of_run);
                        n_errors++;
                    end
                end
            end
            i_out_ready <= !idle_now();
        end
    end

    initial begin
        n_errors = 0;
        n_results = 0;
        n_sweeps = 0;
        n_items = 0;
        quiet = 0;
        sweep_len = 0;
        cfg_sat = 1;
        cfg_lag = 2;
        cfg_pfloor = -1;
        cfg_pceil = -1;
        i_rst_n = 0;
        i_in_valid = 0;
        i_frequency = 0;
        i_level = 0;
        i_last = 0;
        i_out_ready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_random();
        drain();
        $display("Sent %0d samples in %0d sweeps; checked %0d results.",
                 n_items, n_sweeps, n_results);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("[spectrum_peak_finder] OK");
        end else begin
            $display("[spectrum_peak_finder] ERROR");
        end
        $finish;
    end
endmodule
